FILE: rtl/deadzone_camera_follow_defines.svh
// assertion helpers shared by the camera follow modules
`ifndef DEADZONE_CAMERA_FOLLOW_DEFINES_SVH
`define DEADZONE_CAMERA_FOLLOW_DEFINES_SVH

// same-cycle implication, idle during reset
`define DCF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define DCF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dcf_pkg.sv
package dcf_pkg;

  // field widths
  localparam int unsigned POS_W     = 24;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned FT_W      = 16;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned IDX_W     = 4;

  // internal widths, all derived from the formats above
  localparam int unsigned EDGE_W = PIX_W + 3 + FRAC_BITS;
  localparam int unsigned DIFF_W = EDGE_W + 1;
  localparam int unsigned MAG_W  = EDGE_W - 1;
  localparam int unsigned GAIN_W = FT_W + 3;
  localparam int unsigned PROD_W = MAG_W + GAIN_W;
  localparam int unsigned SCL_W  = PROD_W - FT_W;
  localparam int unsigned SUM_W  = SCL_W + 2;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // microprogram
  localparam int unsigned STEP_NUM = 14;
  localparam int unsigned STEP_W   = $clog2(STEP_NUM);

  typedef enum logic [IDX_W-1:0] {
    REG_LOCKED    = 4'd0,
    REG_DZ_WIDTH  = 4'd1,
    REG_DZ_HEIGHT = 4'd2,
    REG_VIEW_W    = 4'd3,
    REG_VIEW_H    = 4'd4,
    REG_WORLD_W   = 4'd5,
    REG_WORLD_H   = 4'd6,
    REG_LOOKAHEAD = 4'd7
  } dcf_reg_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_EDGE,
    OP_DIFF_DZ,
    OP_MUL,
    OP_STEP,
    OP_DIFF_LA,
    OP_CLAMP,
    OP_DONE
  } dcf_op_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_LOCKED,
    COND_INSIDE
  } dcf_cond_e;

  typedef enum logic {
    AXIS_X,
    AXIS_Y
  } dcf_axis_e;

  typedef enum logic {
    GAIN_DZ,
    GAIN_LA
  } dcf_gain_e;

  typedef struct packed {
    dcf_op_e             op;
    dcf_cond_e           cond;
    dcf_axis_e           axis;
    dcf_gain_e           gain;
    logic [STEP_W-1:0]   target;
  } dcf_uword_t;

  typedef struct packed {
    logic      accept;
    dcf_op_e   op;
    dcf_axis_e axis;
    dcf_gain_e gain;
  } dcf_ctrl_t;

  typedef struct packed {
    logic             locked;
    logic [PIX_W-1:0] dz_width;
    logic [PIX_W-1:0] dz_height;
    logic [PIX_W-1:0] view_width;
    logic [PIX_W-1:0] view_height;
    logic [PIX_W-1:0] world_width;
    logic [PIX_W-1:0] world_height;
    logic [PIX_W-1:0] lookahead;
  } dcf_cfg_t;

endpackage

FILE: rtl/deadzone_camera_follow.sv
// Dead zone camera follow with horizontal lookahead.
// Input channel (in_valid_i / in_stall_o): one transfer per frame carrying the
// player position (signed Q16.8), the left/right movement flags and the frame
// time (Q0.16 seconds). Output channel (out_valid_o / out_stall_i): one
// transfer per input transfer with the updated view origin (unsigned Q15.8).
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 locked,
// 1..2 dead zone size, 3..4 view size, 5..6 world size, 7 lookahead); other
// indexes are ignored. Write only while no item is in flight.
// The microprogram runs up to 14 steps, one per cycle, but its last step
// waits while the output register is stalled; an axis inside its dead zone
// skips its two update steps, and with locked set the program jumps from its
// load step to the last step. One item runs at a time, on the single shared
// multiplier and the step counter walking the control store.
// A finished result sits in the output register; a stall there lets the next
// item run, which then waits at its last step until the output register frees.
// Reset clears all configuration registers, the view origin, the output valid
// and the sequencer busy flag, so the input is not stalled.
module deadzone_camera_follow import dcf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_idx_i,
  input  logic [PIX_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [POS_W-1:0] player_x_i,
  input  logic signed [POS_W-1:0] player_y_i,
  input  logic                    move_left_i,
  input  logic                    move_right_i,
  input  logic [FT_W-1:0]         frame_time_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [POS_W-2:0]        view_x_o,
  output logic [POS_W-2:0]        view_y_o
);

  dcf_cfg_t         cfg_q;
  dcf_ctrl_t        ctrl;
  logic             dz_inside;
  logic             out_free;
  logic             out_load;
  logic [POS_W-2:0] org_x, org_y;
  logic             out_valid_q;
  logic [POS_W-2:0] view_x_q, view_y_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOCKED:    cfg_q.locked       <= cfg_data_i[0];
        REG_DZ_WIDTH:  cfg_q.dz_width     <= cfg_data_i;
        REG_DZ_HEIGHT: cfg_q.dz_height    <= cfg_data_i;
        REG_VIEW_W:    cfg_q.view_width   <= cfg_data_i;
        REG_VIEW_H:    cfg_q.view_height  <= cfg_data_i;
        REG_WORLD_W:   cfg_q.world_width  <= cfg_data_i;
        REG_WORLD_H:   cfg_q.world_height <= cfg_data_i;
        REG_LOOKAHEAD: cfg_q.lookahead    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  dcf_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .locked_i    (cfg_q.locked),
    .dz_inside_i (dz_inside),
    .out_free_i  (out_free),
    .ctrl_o      (ctrl),
    .out_load_o  (out_load)
  );

  dcf_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cfg_i        (cfg_q),
    .player_x_i   (player_x_i),
    .player_y_i   (player_y_i),
    .move_left_i  (move_left_i),
    .move_right_i (move_right_i),
    .frame_time_i (frame_time_i),
    .dz_inside_o  (dz_inside),
    .org_x_o      (org_x),
    .org_y_o      (org_y)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      view_x_q <= org_x;
      view_y_q <= org_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign view_x_o    = view_x_q;
  assign view_y_o    = view_y_q;

endmodule

FILE: rtl/dcf_sequencer.sv
`include "deadzone_camera_follow_defines.svh"

module dcf_sequencer import dcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      locked_i,
  input  logic      dz_inside_i,
  input  logic      out_free_i,
  output dcf_ctrl_t ctrl_o,
  output logic      out_load_o
);

  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_Y     = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_LA    = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_DONE  = STEP_W'(13);

  // control store: one word per step
  localparam dcf_uword_t UCODE [STEP_NUM] = '{
    '{OP_LOAD,    COND_LOCKED, AXIS_X, GAIN_DZ, STEP_DONE},
    '{OP_EDGE,    COND_NONE,   AXIS_X, GAIN_DZ, STEP_FIRST},
    '{OP_DIFF_DZ, COND_INSIDE, AXIS_X, GAIN_DZ, STEP_Y},
    '{OP_MUL,     COND_NONE,   AXIS_X, GAIN_DZ, STEP_FIRST},
    '{OP_STEP,    COND_NONE,   AXIS_X, GAIN_DZ, STEP_FIRST},
    '{OP_EDGE,    COND_NONE,   AXIS_Y, GAIN_DZ, STEP_FIRST},
    '{OP_DIFF_DZ, COND_INSIDE, AXIS_Y, GAIN_DZ, STEP_LA},
    '{OP_MUL,     COND_NONE,   AXIS_Y, GAIN_DZ, STEP_FIRST},
    '{OP_STEP,    COND_NONE,   AXIS_Y, GAIN_DZ, STEP_FIRST},
    '{OP_DIFF_LA, COND_NONE,   AXIS_X, GAIN_LA, STEP_FIRST},
    '{OP_MUL,     COND_NONE,   AXIS_X, GAIN_LA, STEP_FIRST},
    '{OP_STEP,    COND_NONE,   AXIS_X, GAIN_LA, STEP_FIRST},
    '{OP_CLAMP,   COND_NONE,   AXIS_X, GAIN_DZ, STEP_FIRST},
    '{OP_DONE,    COND_NONE,   AXIS_X, GAIN_DZ, STEP_FIRST}
  };

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  dcf_uword_t        uword;
  logic              jump;
  logic              accept;

  assign uword      = UCODE[step_q];
  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;

  // jump condition decode
  always_comb begin
    case (uword.cond)
      COND_LOCKED: jump = locked_i;
      COND_INSIDE: jump = dz_inside_i;
      default:     jump = 1'b0;
    endcase
  end

  // control word to the datapath
  always_comb begin
    ctrl_o.accept = accept;
    ctrl_o.op     = busy_q ? uword.op : OP_NOP;
    ctrl_o.axis   = uword.axis;
    ctrl_o.gain   = uword.gain;
    out_load_o    = busy_q && (uword.op == OP_DONE) && out_free_i;
  end

  // step counter and busy flag
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (accept) begin
        busy_d = 1'b1;
        step_d = STEP_FIRST;
      end
    end else if (uword.op == OP_DONE) begin
      if (out_free_i) begin
        busy_d = 1'b0;
      end
    end else if (jump) begin
      step_d = uword.target;
    end else begin
      step_d = step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_FIRST;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  `DCF_ASSERT_NXT(a_accept_starts, accept, busy_q && (step_q == STEP_FIRST), "program not started on transfer")
  `DCF_ASSERT_IMP(a_step_bound, busy_q, step_q <= STEP_DONE, "step counter past end of program")

endmodule

FILE: rtl/dcf_datapath.sv
`include "deadzone_camera_follow_defines.svh"

module dcf_datapath import dcf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dcf_ctrl_t               ctrl_i,
  input  dcf_cfg_t                cfg_i,
  input  logic signed [POS_W-1:0] player_x_i,
  input  logic signed [POS_W-1:0] player_y_i,
  input  logic                    move_left_i,
  input  logic                    move_right_i,
  input  logic [FT_W-1:0]         frame_time_i,
  output logic                    dz_inside_o,
  output logic [POS_W-2:0]        org_x_o,
  output logic [POS_W-2:0]        org_y_o
);

  // clamp to [0, world - view], zero winning
  function automatic logic [POS_W-2:0] clamp_axis(input logic signed [POS_W-1:0] v,
                                                  input logic [PIX_W-1:0] world,
                                                  input logic [PIX_W-1:0] view);
    logic signed [PIX_W:0]    span;
    logic signed [EDGE_W-1:0] hi;
    logic signed [EDGE_W-1:0] ve;
    span = signed'({1'b0, world}) - signed'({1'b0, view});
    hi   = EDGE_W'(span) <<< FRAC_BITS;
    ve   = EDGE_W'(v);
    if (ve > hi) ve = hi;
    if (ve < 0)  ve = '0;
    return ve[POS_W-2:0];
  endfunction

  // latched item
  logic signed [POS_W-1:0] px_q, py_q;
  logic                    left_q, right_q;
  logic [FT_W-1:0]         ft_q;

  // working registers
  logic signed [POS_W-1:0]  w_x_q, w_y_q;
  logic [GAIN_W-1:0]        gain_dz_q, gain_la_q;
  logic signed [EDGE_W-1:0] lo_q, hi_q;
  logic [MAG_W-1:0]         mag_q;
  logic                     neg_q;
  logic [PROD_W-1:0]        prod_q;
  logic [POS_W-2:0]         org_x_q, org_y_q;

  // axis selection
  logic signed [POS_W-1:0] w_sel, p_sel;
  logic [PIX_W-1:0]        view_sel, dz_sel;
  logic [GAIN_W-1:0]       gain_sel;

  assign w_sel    = (ctrl_i.axis == AXIS_Y) ? w_y_q : w_x_q;
  assign p_sel    = (ctrl_i.axis == AXIS_Y) ? py_q : px_q;
  assign view_sel = (ctrl_i.axis == AXIS_Y) ? cfg_i.view_height : cfg_i.view_width;
  assign dz_sel   = (ctrl_i.axis == AXIS_Y) ? cfg_i.dz_height : cfg_i.dz_width;
  assign gain_sel = (ctrl_i.gain == GAIN_LA) ? gain_la_q : gain_dz_q;

  // dead zone edges around the current origin
  logic signed [PIX_W:0]    vmd;
  logic [PIX_W:0]           vpd;
  logic signed [EDGE_W-1:0] lo_full, hi_full, lo_d, hi_d;

  always_comb begin
    vmd     = signed'({1'b0, view_sel}) - signed'({1'b0, dz_sel});
    vpd     = {1'b0, view_sel} + {1'b0, dz_sel};
    lo_full = EDGE_W'(vmd) <<< FRAC_BITS;
    hi_full = EDGE_W'(signed'({1'b0, vpd})) <<< FRAC_BITS;
    lo_d    = EDGE_W'(w_sel) + (lo_full >>> 1);
    hi_d    = EDGE_W'(w_sel) + (hi_full >>> 1);
  end

  // overshoot against the stored edges, low edge tested first
  logic signed [EDGE_W-1:0] p_ext, dz_diff;
  logic                     below, above;

  always_comb begin
    p_ext       = EDGE_W'(p_sel);
    below       = p_ext < lo_q;
    above       = p_ext > hi_q;
    dz_inside_o = !below && !above;
    dz_diff     = below ? (lo_q - p_ext) : (p_ext - hi_q);
  end

  // lookahead error: target minus working x
  logic signed [DIFF_W-1:0] hv_full, la_full, lead, la_diff, la_abs;

  always_comb begin
    hv_full = DIFF_W'(signed'({1'b0, cfg_i.view_width})) <<< FRAC_BITS;
    la_full = DIFF_W'(signed'({1'b0, cfg_i.lookahead})) <<< FRAC_BITS;
    if (left_q) begin
      lead = -la_full;
    end else if (right_q) begin
      lead = la_full;
    end else begin
      lead = '0;
    end
    la_diff = DIFF_W'(px_q) - (hv_full >>> 1) + lead - DIFF_W'(w_x_q);
    la_abs  = la_diff[DIFF_W-1] ? -la_diff : la_diff;
  end

  // scaled step, applied toward the sign held in neg_q, then saturated
  logic [SCL_W-1:0]        scaled;
  logic signed [SUM_W-1:0] w_ext, sc_ext, sum;
  logic signed [POS_W-1:0] step_res;

  always_comb begin
    scaled = prod_q[PROD_W-1:FT_W];
    w_ext  = SUM_W'(w_sel);
    sc_ext = signed'(SUM_W'(scaled));
    sum    = neg_q ? (w_ext - sc_ext) : (w_ext + sc_ext);
    if (sum > SUM_W'(POS_MAX)) begin
      step_res = POS_MAX;
    end else if (sum < SUM_W'(POS_MIN)) begin
      step_res = POS_MIN;
    end else begin
      step_res = signed'(sum[POS_W-1:0]);
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      px_q    <= player_x_i;
      py_q    <= player_y_i;
      left_q  <= move_left_i;
      right_q <= move_right_i;
      ft_q    <= frame_time_i;
    end
  end

  // working registers, one operation per step
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LOAD: begin
        w_x_q     <= signed'({1'b0, org_x_q});
        w_y_q     <= signed'({1'b0, org_y_q});
        gain_dz_q <= (GAIN_W'(ft_q) << 2) + (GAIN_W'(ft_q) << 1);
        gain_la_q <= (GAIN_W'(ft_q) << 1) + GAIN_W'(ft_q);
      end
      OP_EDGE: begin
        lo_q <= lo_d;
        hi_q <= hi_d;
      end
      OP_DIFF_DZ: begin
        mag_q <= MAG_W'(dz_diff);
        neg_q <= below;
      end
      OP_DIFF_LA: begin
        mag_q <= MAG_W'(la_abs);
        neg_q <= la_diff[DIFF_W-1];
      end
      OP_MUL: begin
        prod_q <= PROD_W'(mag_q) * PROD_W'(gain_sel);
      end
      OP_STEP: begin
        if (ctrl_i.axis == AXIS_Y) begin
          w_y_q <= step_res;
        end else begin
          w_x_q <= step_res;
        end
      end
      default: begin
      end
    endcase
  end

  // view origin state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
    end else if (ctrl_i.op == OP_CLAMP) begin
      org_x_q <= clamp_axis(w_x_q, cfg_i.world_width, cfg_i.view_width);
      org_y_q <= clamp_axis(w_y_q, cfg_i.world_height, cfg_i.view_height);
    end
  end

  assign org_x_o = org_x_q;
  assign org_y_o = org_y_q;

  `DCF_ASSERT_NXT(a_outside_nonzero, (ctrl_i.op == OP_DIFF_DZ) && !dz_inside_o, mag_q != '0, "zero overshoot outside dead zone")
  `DCF_ASSERT_NXT(a_gain_ratio, ctrl_i.op == OP_LOAD, gain_dz_q == (gain_la_q << 1), "dead zone gain not twice lookahead gain")

endmodule

FILE: sim/testbench.sv
module testbench import dcf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // one frame update and one view origin
  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic                    left;
    logic                    right;
    logic [FT_W-1:0]         ft;
  } frame_t;

  typedef struct packed {
    logic [POS_W-2:0] vx;
    logic [POS_W-2:0] vy;
  } view_t;

  localparam longint Q_ONE     = 64'sd1 <<< FRAC_BITS;
  localparam longint FT_ONE    = 64'sd1 <<< FT_W;
  localparam longint SAT_HI    = 64'sd8388607;
  localparam longint SAT_LO    = -64'sd8388608;
  localparam int     REG_COUNT = int'(REG_LOOKAHEAD) + 1;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    cfg_we_i     = 1'b0;
  logic [IDX_W-1:0]        cfg_idx_i    = '0;
  logic [PIX_W-1:0]        cfg_data_i   = '0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic signed [POS_W-1:0] player_x_i   = '0;
  logic signed [POS_W-1:0] player_y_i   = '0;
  logic                    move_left_i  = 1'b0;
  logic                    move_right_i = 1'b0;
  logic [FT_W-1:0]         frame_time_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic [POS_W-2:0]        view_x_o;
  logic [POS_W-2:0]        view_y_o;

  // predictor state and configuration
  dcf_cfg_t cam_cfg = '0;
  longint   cam_x   = 0;
  longint   cam_y   = 0;

  // player wander state for the random part
  longint walk_x = 0;
  longint walk_y = 0;

  view_t       pending_views[$];
  view_t       due_view;
  int unsigned mismatch_count = 0;
  int unsigned rx_wait        = 0;
  bit          tx_quiet       = 1'b0;
  bit          rx_quiet       = 1'b0;

  deadzone_camera_follow DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .player_x_i   (player_x_i),
    .player_y_i   (player_y_i),
    .move_left_i  (move_left_i),
    .move_right_i (move_right_i),
    .frame_time_i (frame_time_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .view_x_o     (view_x_o),
    .view_y_o     (view_y_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // fixed-point helpers for the predictor
  function automatic longint halve_down(input longint v);
    return v >>> 1;
  endfunction

  function automatic longint gain_apply(input longint v, input longint g);
    return (v * g) / FT_ONE;
  endfunction

  function automatic longint pos_sat(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint fit_world(input longint v, input longint world,
                                       input longint view);
    longint top;
    top = (world - view) * Q_ONE;
    if (v > top) v = top;
    if (v < 0) v = 0;
    return v;
  endfunction

  // move one axis toward the player when it leaves the dead zone
  function automatic longint chase_axis(input longint org, input longint player,
                                        input longint view, input longint dz,
                                        input longint g);
    longint lo;
    longint hi;
    lo = org + halve_down((view - dz) * Q_ONE);
    hi = org + halve_down((view + dz) * Q_ONE);
    if (player < lo) return pos_sat(org - gain_apply(lo - player, g));
    if (player > hi) return pos_sat(org + gain_apply(player - hi, g));
    return org;
  endfunction

  // next view origin for one frame, updates the predictor state
  function automatic view_t follow_player(input frame_t f);
    longint px;
    longint py;
    longint g_dz;
    longint g_la;
    longint lead;
    longint aim;
    longint nx;
    longint ny;
    view_t  v;
    if (!cam_cfg.locked) begin
      px   = longint'($signed(f.px));
      py   = longint'($signed(f.py));
      g_dz = 6 * longint'(f.ft);
      g_la = 3 * longint'(f.ft);
      nx = chase_axis(cam_x, px, longint'(cam_cfg.view_width),
                      longint'(cam_cfg.dz_width), g_dz);
      ny = chase_axis(cam_y, py, longint'(cam_cfg.view_height),
                      longint'(cam_cfg.dz_height), g_dz);
      if (f.left) lead = -longint'(cam_cfg.lookahead) * Q_ONE;
      else if (f.right) lead = longint'(cam_cfg.lookahead) * Q_ONE;
      else lead = 0;
      aim = px - halve_down(longint'(cam_cfg.view_width) * Q_ONE) + lead;
      nx  = pos_sat(nx + gain_apply(aim - nx, g_la));
      cam_x = fit_world(nx, longint'(cam_cfg.world_width), longint'(cam_cfg.view_width));
      cam_y = fit_world(ny, longint'(cam_cfg.world_height), longint'(cam_cfg.view_height));
    end
    v.vx = cam_x[POS_W-2:0];
    v.vy = cam_y[POS_W-2:0];
    return v;
  endfunction

  function automatic frame_t make_frame(input longint px, input longint py,
                                        input bit left, input bit right,
                                        input longint ft);
    frame_t f;
    f.px    = px[POS_W-1:0];
    f.py    = py[POS_W-1:0];
    f.left  = left;
    f.right = right;
    f.ft    = ft[FT_W-1:0];
    return f;
  endfunction

  function automatic dcf_cfg_t make_setting(input bit locked,
                                            input int dzw, input int dzh,
                                            input int vw, input int vh,
                                            input int ww, input int wh,
                                            input int la);
    dcf_cfg_t c;
    c.locked       = locked;
    c.dz_width     = PIX_W'(dzw);
    c.dz_height    = PIX_W'(dzh);
    c.view_width   = PIX_W'(vw);
    c.view_height  = PIX_W'(vh);
    c.world_width  = PIX_W'(ww);
    c.world_height = PIX_W'(wh);
    c.lookahead    = PIX_W'(la);
    return c;
  endfunction

  // corner-biased pixel size
  function automatic logic [PIX_W-1:0] pick_pixels();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic dcf_cfg_t draw_setting(input bit wild);
    dcf_cfg_t c;
    c.locked = ($urandom_range(0, 5) == 0);
    if (wild) begin
      c.dz_width     = pick_pixels();
      c.dz_height    = pick_pixels();
      c.view_width   = pick_pixels();
      c.view_height  = pick_pixels();
      c.world_width  = pick_pixels();
      c.world_height = pick_pixels();
      c.lookahead    = pick_pixels();
    end else begin
      c.view_width   = PIX_W'($urandom_range(32, 640));
      c.view_height  = PIX_W'($urandom_range(32, 480));
      c.dz_width     = PIX_W'($urandom_range(0, int'(c.view_width)));
      c.dz_height    = PIX_W'($urandom_range(0, int'(c.view_height)));
      c.world_width  = PIX_W'($urandom_range(int'(c.view_width), 6000));
      c.world_height = PIX_W'($urandom_range(int'(c.view_height), 6000));
      c.lookahead    = PIX_W'($urandom_range(0, 200));
    end
    return c;
  endfunction

  // player drifting around the world, now and then anywhere at all
  function automatic frame_t wander_frame();
    frame_t f;
    longint span_x;
    longint span_y;
    f.left  = 1'($urandom_range(0, 1));
    f.right = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      f.px = POS_W'($urandom);
      f.py = POS_W'($urandom);
      f.ft = FT_W'($urandom);
      return f;
    end
    span_x = (longint'(cam_cfg.world_width) + 64) * Q_ONE;
    span_y = (longint'(cam_cfg.world_height) + 64) * Q_ONE;
    if ($urandom_range(0, 49) == 0) begin
      walk_x = longint'($urandom_range(0, 65535)) * span_x / 65536 - 32 * Q_ONE;
      walk_y = longint'($urandom_range(0, 65535)) * span_y / 65536 - 32 * Q_ONE;
    end else begin
      walk_x = walk_x + longint'($urandom_range(0, 8192)) - 4096;
      walk_y = walk_y + longint'($urandom_range(0, 8192)) - 4096;
    end
    walk_x = pos_sat(walk_x);
    walk_y = pos_sat(walk_y);
    f.px = walk_x[POS_W-1:0];
    f.py = walk_y[POS_W-1:0];
    if ($urandom_range(0, 7) == 0) f.ft = FT_W'($urandom);
    else f.ft = FT_W'($urandom_range(0, 4000));
    return f;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // register write, enable left high for a following write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [PIX_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_LOCKED:    cam_cfg.locked       = data[0];
      REG_DZ_WIDTH:  cam_cfg.dz_width     = data;
      REG_DZ_HEIGHT: cam_cfg.dz_height    = data;
      REG_VIEW_W:    cam_cfg.view_width   = data;
      REG_VIEW_H:    cam_cfg.view_height  = data;
      REG_WORLD_W:   cam_cfg.world_width  = data;
      REG_WORLD_H:   cam_cfg.world_height = data;
      REG_LOOKAHEAD: cam_cfg.lookahead    = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input dcf_cfg_t c);
    write_reg(REG_LOCKED,    PIX_W'(c.locked));
    write_reg(REG_DZ_WIDTH,  c.dz_width);
    write_reg(REG_DZ_HEIGHT, c.dz_height);
    write_reg(REG_VIEW_W,    c.view_width);
    write_reg(REG_VIEW_H,    c.view_height);
    write_reg(REG_WORLD_W,   c.world_width);
    write_reg(REG_WORLD_H,   c.world_height);
    write_reg(REG_LOOKAHEAD, c.lookahead);
    cfg_we_i <= 1'b0;
  endtask

  // drop valid and wait until every predicted view has arrived
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one frame transfer; valid stays high for a back-to-back successor
  task automatic send_frame(input frame_t f);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    player_x_i   <= f.px;
    player_y_i   <= f.py;
    move_left_i  <= f.left;
    move_right_i <= f.right;
    frame_time_i <= f.ft;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_views.push_back(follow_player(f));
  endtask

  // result check and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_views.size() == 0) begin
          report_mismatch($sformatf("view %0h,%0h with nothing predicted",
                                    view_x_o, view_y_o));
        end else begin
          due_view = pending_views.pop_front();
          if (view_x_o !== due_view.vx)
            report_mismatch($sformatf("view_x %0h, predicted %0h", view_x_o, due_view.vx));
          if (view_y_o !== due_view.vy)
            report_mismatch($sformatf("view_y %0h, predicted %0h", view_y_o, due_view.vy));
        end
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 7);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall_i <= (rx_wait != 0);
    end
  end

  // reset values, field extremes, both flags set and each flag alone
  task automatic test_reset_defaults();
    send_frame(make_frame(SAT_HI, SAT_LO, 1'b1, 1'b1, FT_ONE - 1));
    send_frame(make_frame(SAT_LO, SAT_HI, 1'b0, 1'b1, 0));
    send_frame(make_frame(0, 0, 1'b1, 0, FT_ONE - 1));
  endtask

  // saturation of the origin, clamp bound beyond the position range
  task automatic test_saturation();
    wait_idle();
    apply_setting(make_setting(0, 0, 0, 0, 0, 65535, 65535, 65535));
    send_frame(make_frame(SAT_HI, SAT_HI, 1'b0, 1'b1, FT_ONE - 1));
    send_frame(make_frame(SAT_LO, SAT_LO, 1'b1, 1'b0, FT_ONE - 1));
    send_frame(make_frame(SAT_HI, SAT_LO, 1'b1, 1'b1, FT_ONE - 1));
    send_frame(make_frame(0, 0, 1'b0, 1'b0, FT_ONE / 2));
  endtask

  // dead zone wider than the view: low edge below the view origin
  task automatic test_wide_deadzone();
    wait_idle();
    apply_setting(make_setting(0, 65535, 40000, 320, 240, 4000, 3000, 64));
    send_frame(make_frame(SAT_LO, 500 * Q_ONE, 1'b0, 1'b1, 4000));
    send_frame(make_frame(SAT_HI, SAT_HI, 1'b0, 1'b1, 4000));
    send_frame(make_frame(1000 * Q_ONE, SAT_LO, 1'b1, 1'b0, 1092));
    send_frame(make_frame(-200 * Q_ONE, 100 * Q_ONE, 1'b0, 1'b0, FT_ONE - 1));
  endtask

  // world smaller than the view pins the axis to 0
  task automatic test_small_world();
    wait_idle();
    apply_setting(make_setting(0, 16, 16, 320, 240, 100, 50, 30));
    send_frame(make_frame(800 * Q_ONE, 600 * Q_ONE, 1'b0, 1'b1, 8000));
    send_frame(make_frame(SAT_HI, SAT_HI, 1'b0, 1'b0, FT_ONE - 1));
    send_frame(make_frame(-5 * Q_ONE, 7 * Q_ONE, 1'b1, 1'b0, 2000));
  endtask

  // hold while locked, unused register indexes, lock bit taken from bit 0
  task automatic test_lock_and_unused_index();
    wait_idle();
    apply_setting(make_setting(0, 64, 48, 320, 240, 2000, 1500, 40));
    send_frame(make_frame(800 * Q_ONE, 600 * Q_ONE, 1'b0, 1'b1, 8192));
    send_frame(make_frame(900 * Q_ONE, 650 * Q_ONE, 1'b0, 1'b1, 8192));
    wait_idle();
    write_reg(REG_LOCKED, PIX_W'(1));
    cfg_we_i <= 1'b0;
    send_frame(make_frame(1500 * Q_ONE, 1200 * Q_ONE, 1'b1, 1'b0, FT_ONE - 1));
    send_frame(make_frame(SAT_LO, SAT_HI, 1'b0, 1'b1, FT_ONE - 1));
    send_frame(make_frame(0, 0, 1'b0, 1'b0, 1092));
    wait_idle();
    for (int i = REG_COUNT; i < (1 << IDX_W); i++) write_reg(IDX_W'(i), '1);
    cfg_we_i <= 1'b0;
    send_frame(make_frame(300 * Q_ONE, 200 * Q_ONE, 1'b1, 1'b1, 5000));
    send_frame(make_frame(1200 * Q_ONE, 900 * Q_ONE, 1'b0, 1'b1, 5000));
    wait_idle();
    write_reg(REG_LOCKED, PIX_W'(16'hFFFE));
    cfg_we_i <= 1'b0;
    send_frame(make_frame(1200 * Q_ONE, 900 * Q_ONE, 1'b0, 1'b1, 5000));
    send_frame(make_frame(100 * Q_ONE, 80 * Q_ONE, 1'b1, 1'b0, 30000));
  endtask

  // random settings with a wandering player, idling varied per phase
  task automatic test_random_follow();
    for (int phase = 0; phase < 11; phase++) begin
      tx_quiet = (phase % 3 == 1);
      rx_quiet = (phase % 3 == 2) || (phase == 4);
      wait_idle();
      apply_setting(draw_setting(phase % 4 == 3));
      walk_x = longint'(cam_cfg.world_width) * Q_ONE / 2;
      walk_y = longint'(cam_cfg.world_height) * Q_ONE / 2;
      for (int n = 0; n < 100; n++) begin
        // occasional full drain before the next frame
        if ($urandom_range(0, 59) == 0) wait_idle();
        send_frame(wander_frame());
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_saturation();
    test_wide_deadzone();
    test_small_world();
    test_lock_and_unused_index();
    test_random_follow();
    wait_idle();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run time limit
  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/dcf_pkg.sv
rtl/dcf_sequencer.sv
rtl/dcf_datapath.sv
rtl/deadzone_camera_follow.sv
sim/testbench.sv
